FILE: design/rmda_pkg.sv
package rmda_pkg;

    // default build-time sizes
    localparam int DEF_NODES         = 8;
    localparam int DEF_QUEUE_DEPTH   = 16;
    localparam int DEF_PAYLOAD_WIDTH = 32;

    // width of live-node counts and node counters (covers up to 64 nodes)
    localparam int LIVE_W = 7;
    // width of a node index carried in the slot command
    localparam int IDX_W  = 6;

    // register map
    localparam logic       REG_ACTIVE_NODES   = 1'b0;
    localparam logic [3:0] ACTIVE_NODES_RESET = 4'd8;

    // request kinds on the input tuser
    localparam logic REQ_SEND = 1'b0;
    localparam logic REQ_TICK = 1'b1;

    // result kinds on the output tuser
    localparam logic KIND_STATUS = 1'b0;
    localparam logic KIND_REPORT = 1'b1;

    // send status codes
    localparam logic [1:0] STATUS_OK   = 2'd0;
    localparam logic [1:0] STATUS_FULL = 2'd1;
    localparam logic [1:0] STATUS_BAD  = 2'd2;

    // destination code for broadcast (-1 in four bits)
    localparam logic [3:0] DEST_BCAST = 4'hF;

    // operations on the receive slot file
    typedef enum logic [1:0] {
        SOP_NONE,
        SOP_CLEAR,
        SOP_BCAST,
        SOP_UCAST
    } t_slot_op;

    // slot file command: idx is the receiver (unicast) or the excluded sender (broadcast)
    typedef struct packed {
        t_slot_op            op;
        logic [IDX_W-1:0]    idx;
        logic [LIVE_W-1:0]   lim;
        logic [2:0]          src;
    } t_slot_cmd;

endpackage

FILE: design/rmda_queue_mem.sv
module rmda_queue_mem #(
    parameter int AW = 7,
    parameter int DW = 36
) (
    input  logic          i_clk,
    input  logic          i_wr_en,
    input  logic [AW-1:0] i_wr_addr,
    input  logic [DW-1:0] i_wr_data,
    input  logic [AW-1:0] i_rd_addr,
    output logic [DW-1:0] o_rd_data
);

    logic [DW-1:0] r_mem [2**AW];
    logic [DW-1:0] r_rd_data;

    // single write port
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    // registered read port
    always_ff @(posedge i_clk) begin
        r_rd_data <= r_mem[i_rd_addr];
    end

    assign o_rd_data = r_rd_data;

endmodule

FILE: design/rmda_slots.sv
module rmda_slots #(
    parameter int NODES         = rmda_pkg::DEF_NODES,
    parameter int PAYLOAD_WIDTH = rmda_pkg::DEF_PAYLOAD_WIDTH
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  rmda_pkg::t_slot_cmd       i_cmd,
    input  logic [PAYLOAD_WIDTH-1:0]  i_data,
    input  logic [$clog2(NODES)-1:0]  i_rd_idx,
    output logic                      o_rd_taken,
    output logic [2:0]                o_rd_src,
    output logic [PAYLOAD_WIDTH-1:0]  o_rd_data
);

    localparam int NW = $clog2(NODES);

    logic [NODES-1:0]         r_taken;
    logic [2:0]               r_src  [NODES];
    logic [PAYLOAD_WIDTH-1:0] r_data [NODES];

    logic [NW-1:0] w_idx;
    logic [NODES-1:0] w_bcast_hit;

    assign w_idx = i_cmd.idx[NW-1:0];

    // slots a broadcast fills: live, not the sender, still free
    always_comb begin
        for (int k = 0; k < NODES; k++) begin
            w_bcast_hit[k] = (rmda_pkg::LIVE_W'(k) < i_cmd.lim)
                             && (NW'(k) != w_idx) && !r_taken[k];
        end
    end

    // occupancy flags
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_taken <= '0;
        end else begin
            case (i_cmd.op)
                rmda_pkg::SOP_CLEAR: r_taken <= '0;
                rmda_pkg::SOP_BCAST: r_taken <= r_taken | w_bcast_hit;
                rmda_pkg::SOP_UCAST: r_taken[w_idx] <= 1'b1;
                default: ;
            endcase
        end
    end

    // slot contents
    always_ff @(posedge i_clk) begin
        case (i_cmd.op)
            rmda_pkg::SOP_BCAST: begin
                for (int k = 0; k < NODES; k++) begin
                    if (w_bcast_hit[k]) begin
                        r_src[k]  <= i_cmd.src;
                        r_data[k] <= i_data;
                    end
                end
            end
            rmda_pkg::SOP_UCAST: begin
                r_src[w_idx]  <= i_cmd.src;
                r_data[w_idx] <= i_data;
            end
            default: ;
        endcase
    end

    // read port
    assign o_rd_taken = r_taken[i_rd_idx];
    assign o_rd_src   = r_src[i_rd_idx];
    assign o_rd_data  = r_data[i_rd_idx];

    // a clear leaves every slot free
    a_clear_empties: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.op == rmda_pkg::SOP_CLEAR |=> r_taken == '0)
        else $error("slot file not empty after clear");

endmodule

FILE: design/round_message_delivery_arbiter.sv
// Per-node message queues with round-based delivery. A send beat (tuser 0) appends one
// message to its sender's queue unless it is bad or full, and answers with one status
// beat (accepted, queue full, or bad sender/destination) in the cycle after acceptance.
// A tick beat (tuser 1) clears all receive slots, scans the live senders in index order,
// then returns one report beat per live node, tlast on the final one. The scan visits
// each sender in a read state and then a decision state, because the queue store has a
// single registered read port, and each report is built in a report state and held in
// an output state until taken. The block takes no new beat until the last result of
// the current one has been taken. Program active_nodes only while idle.
module round_message_delivery_arbiter #(
    parameter int NODES         = rmda_pkg::DEF_NODES,
    parameter int QUEUE_DEPTH   = rmda_pkg::DEF_QUEUE_DEPTH,
    parameter int PAYLOAD_WIDTH = rmda_pkg::DEF_PAYLOAD_WIDTH
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // request stream
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [39:0] s_axis_tdata,   // sender[2:0], dest[6:3], payload[38:7], zero[39]
    input  logic        s_axis_tuser,   // req_type
    // result stream
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [47:0] m_axis_tdata,   // status[1:0], node[4:2], delivered[5], source[8:6],
                                        // data[40:9], zero[47:41]
    output logic        m_axis_tuser,   // kind
    output logic        m_axis_tlast,   // last
    // register port
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    localparam int NW = $clog2(NODES);
    localparam int HW = $clog2(QUEUE_DEPTH);
    localparam int CW = $clog2(QUEUE_DEPTH + 1);
    localparam int AW = $clog2(NODES * QUEUE_DEPTH);
    localparam int EW = 4 + PAYLOAD_WIDTH;
    localparam int LW = rmda_pkg::LIVE_W;

    typedef enum logic [2:0] {
        S_IDLE,
        S_RD,
        S_EX,
        S_REP,
        S_OUT
    } t_state;

    // ---------------------------------------------------------------
    // registers
    // ---------------------------------------------------------------
    logic [3:0]    r_active;
    logic [HW-1:0] r_head [NODES];
    logic [CW-1:0] r_cnt  [NODES];

    t_state        r_state, n_state;
    logic [LW-1:0] r_s, n_s;
    logic [LW-1:0] r_k, n_k;
    logic          r_ovalid, n_ovalid;
    logic          r_kind, n_kind;
    logic [1:0]    r_status, n_status;
    logic [2:0]    r_node, n_node;
    logic          r_dlv, n_dlv;
    logic [2:0]    r_src, n_src;
    logic [31:0]   r_data, n_data;
    logic          r_last, n_last;

    // ---------------------------------------------------------------
    // register port
    // ---------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_active <= rmda_pkg::ACTIVE_NODES_RESET;
        end else if (psel && penable && pwrite && paddr[2] == rmda_pkg::REG_ACTIVE_NODES) begin
            r_active <= pwdata[3:0];
        end
    end

    assign pready = 1'b1;
    assign prdata = (paddr[2] == rmda_pkg::REG_ACTIVE_NODES) ? 32'(r_active) : 32'd0;

    // live node count, clamped to 1..NODES
    logic [LW-1:0] w_live;
    always_comb begin
        if (r_active == 4'd0) begin
            w_live = LW'(1);
        end else if (LW'(r_active) > LW'(NODES)) begin
            w_live = LW'(NODES);
        end else begin
            w_live = LW'(r_active);
        end
    end

    // ---------------------------------------------------------------
    // send path: check and enqueue
    // ---------------------------------------------------------------
    logic          w_accept;
    logic [2:0]    w_sender;
    logic [3:0]    w_dest;
    logic [31:0]   w_payload;
    logic [LW-1:0] w_snd_ext;
    logic [LW-1:0] w_dst_ext;
    logic [NW-1:0] w_snd_idx;
    logic          w_bad;
    logic          w_full;
    logic [HW:0]   w_tail_sum;
    logic [HW-1:0] w_tail;
    logic          w_wr_en;
    logic [AW-1:0] w_wr_addr;
    logic [63:0]   w_pay64;
    logic [EW-1:0] w_wr_data;

    assign w_accept  = s_axis_tvalid && s_axis_tready;
    assign w_sender  = s_axis_tdata[2:0];
    assign w_dest    = s_axis_tdata[6:3];
    assign w_payload = s_axis_tdata[38:7];
    assign w_snd_ext = LW'(w_sender);
    assign w_dst_ext = LW'(w_dest[2:0]);
    assign w_snd_idx = w_snd_ext[NW-1:0];

    assign w_bad = (w_snd_ext >= w_live)
                   || (w_dest[3] && w_dest != rmda_pkg::DEST_BCAST)
                   || (!w_dest[3] && w_dst_ext >= w_live);
    assign w_full = r_cnt[w_snd_idx] == CW'(QUEUE_DEPTH);

    // tail slot, wrapped once around the ring
    assign w_tail_sum = (HW+1)'(r_head[w_snd_idx]) + (HW+1)'(r_cnt[w_snd_idx]);
    assign w_tail     = (w_tail_sum >= (HW+1)'(QUEUE_DEPTH))
                        ? HW'(w_tail_sum - (HW+1)'(QUEUE_DEPTH)) : HW'(w_tail_sum);

    assign w_wr_en   = w_accept && s_axis_tuser == rmda_pkg::REQ_SEND && !w_bad && !w_full;
    assign w_wr_addr = AW'(int'(w_snd_idx) * QUEUE_DEPTH + int'(w_tail));
    assign w_pay64   = 64'(w_payload);
    assign w_wr_data = {w_dest, w_pay64[PAYLOAD_WIDTH-1:0]};

    // ---------------------------------------------------------------
    // scan path: head fetch and delivery decision
    // ---------------------------------------------------------------
    logic [NW-1:0] w_scan_idx;
    logic [AW-1:0] w_rd_addr;
    logic [EW-1:0] w_entry;
    logic [3:0]    w_edest;
    logic [LW-1:0] w_edst_ext;
    logic [NW-1:0] w_edst_idx;
    logic          w_pop;

    assign w_scan_idx = r_s[NW-1:0];
    assign w_rd_addr  = AW'(int'(w_scan_idx) * QUEUE_DEPTH + int'(r_head[w_scan_idx]));
    assign w_edest    = w_entry[EW-1:EW-4];
    assign w_edst_ext = LW'(w_edest[2:0]);
    assign w_edst_idx = w_edst_ext[NW-1:0];

    rmda_queue_mem #(
        .AW (AW),
        .DW (EW)
    ) u_queue_mem (
        .i_clk     (i_clk),
        .i_wr_en   (w_wr_en),
        .i_wr_addr (w_wr_addr),
        .i_wr_data (w_wr_data),
        .i_rd_addr (w_rd_addr),
        .o_rd_data (w_entry)
    );

    // ---------------------------------------------------------------
    // receive slots
    // ---------------------------------------------------------------
    rmda_pkg::t_slot_cmd      w_cmd;
    logic [NW-1:0]            w_slot_rd_idx;
    logic                     w_rd_taken;
    logic [2:0]               w_rd_src;
    logic [PAYLOAD_WIDTH-1:0] w_rd_data;
    logic [63:0]              w_rd_data64;

    assign w_rd_data64 = 64'(w_rd_data);

    rmda_slots #(
        .NODES         (NODES),
        .PAYLOAD_WIDTH (PAYLOAD_WIDTH)
    ) u_slots (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cmd      (w_cmd),
        .i_data     (w_entry[PAYLOAD_WIDTH-1:0]),
        .i_rd_idx   (w_slot_rd_idx),
        .o_rd_taken (w_rd_taken),
        .o_rd_src   (w_rd_src),
        .o_rd_data  (w_rd_data)
    );

    // ---------------------------------------------------------------
    // queue pointers
    // ---------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < NODES; i++) begin
                r_head[i] <= '0;
                r_cnt[i]  <= '0;
            end
        end else if (w_wr_en) begin
            r_cnt[w_snd_idx] <= r_cnt[w_snd_idx] + CW'(1);
        end else if (w_pop) begin
            r_head[w_scan_idx] <= (r_head[w_scan_idx] == HW'(QUEUE_DEPTH - 1))
                                  ? '0 : r_head[w_scan_idx] + HW'(1);
            r_cnt[w_scan_idx]  <= r_cnt[w_scan_idx] - CW'(1);
        end
    end

    // ---------------------------------------------------------------
    // sequencer
    // ---------------------------------------------------------------
    always_comb begin
        n_state       = r_state;
        n_s           = r_s;
        n_k           = r_k;
        n_ovalid      = r_ovalid;
        n_kind        = r_kind;
        n_status      = r_status;
        n_node        = r_node;
        n_dlv         = r_dlv;
        n_src         = r_src;
        n_data        = r_data;
        n_last        = r_last;
        w_pop         = 1'b0;
        w_cmd.op      = rmda_pkg::SOP_NONE;
        w_cmd.idx     = rmda_pkg::IDX_W'(w_scan_idx);
        w_cmd.lim     = w_live;
        w_cmd.src     = r_s[2:0];
        w_slot_rd_idx = r_k[NW-1:0];

        case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    if (s_axis_tuser == rmda_pkg::REQ_SEND) begin
                        // status beat for a send
                        n_kind   = rmda_pkg::KIND_STATUS;
                        n_status = w_bad ? rmda_pkg::STATUS_BAD
                                 : (w_full ? rmda_pkg::STATUS_FULL : rmda_pkg::STATUS_OK);
                        n_node   = 3'd0;
                        n_dlv    = 1'b0;
                        n_src    = 3'd0;
                        n_data   = 32'd0;
                        n_last   = 1'b1;
                        n_ovalid = 1'b1;
                        n_state  = S_OUT;
                    end else begin
                        // tick: empty slots, start the scan at sender zero
                        w_cmd.op = rmda_pkg::SOP_CLEAR;
                        n_s      = '0;
                        n_k      = '0;
                        n_state  = S_RD;
                    end
                end
            end
            S_RD: begin
                n_state = S_EX;
            end
            S_EX: begin
                if (r_cnt[w_scan_idx] != '0) begin
                    if (w_edest == rmda_pkg::DEST_BCAST) begin
                        w_cmd.op = rmda_pkg::SOP_BCAST;
                        w_pop    = 1'b1;
                    end else if (w_edest[3] || w_edst_ext >= w_live) begin
                        // destination no longer live
                        w_pop = 1'b1;
                    end else begin
                        w_slot_rd_idx = w_edst_idx;
                        if (!w_rd_taken) begin
                            w_cmd.op  = rmda_pkg::SOP_UCAST;
                            w_cmd.idx = rmda_pkg::IDX_W'(w_edst_idx);
                            w_pop     = 1'b1;
                        end
                    end
                end
                if (r_s + LW'(1) == w_live) begin
                    n_state = S_REP;
                end else begin
                    n_s     = r_s + LW'(1);
                    n_state = S_RD;
                end
            end
            S_REP: begin
                // report beat for node r_k
                n_kind   = rmda_pkg::KIND_REPORT;
                n_status = rmda_pkg::STATUS_OK;
                n_node   = r_k[2:0];
                n_dlv    = w_rd_taken;
                n_src    = w_rd_taken ? w_rd_src : 3'd0;
                n_data   = w_rd_taken ? w_rd_data64[31:0] : 32'd0;
                n_last   = (r_k + LW'(1) == w_live);
                n_ovalid = 1'b1;
                n_state  = S_OUT;
            end
            S_OUT: begin
                if (m_axis_tready) begin
                    n_ovalid = 1'b0;
                    if (r_last) begin
                        n_state = S_IDLE;
                    end else begin
                        n_k     = r_k + LW'(1);
                        n_state = S_REP;
                    end
                end
            end
            default: begin
                n_state  = S_IDLE;
                n_ovalid = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_s      <= '0;
            r_k      <= '0;
            r_ovalid <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_s      <= n_s;
            r_k      <= n_k;
            r_ovalid <= n_ovalid;
            r_kind   <= n_kind;
            r_status <= n_status;
            r_node   <= n_node;
            r_dlv    <= n_dlv;
            r_src    <= n_src;
            r_data   <= n_data;
            r_last   <= n_last;
        end
    end

    // ---------------------------------------------------------------
    // stream outputs
    // ---------------------------------------------------------------
    assign s_axis_tready = (r_state == S_IDLE);
    assign m_axis_tvalid = r_ovalid;
    assign m_axis_tuser  = r_kind;
    assign m_axis_tlast  = r_last;
    assign m_axis_tdata  = {7'd0, r_data, r_src, r_dlv, r_node, r_status};

    // ---------------------------------------------------------------
    // checks
    // ---------------------------------------------------------------
    a_one_side: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(s_axis_tready && m_axis_tvalid))
        else $error("input taken while a result is pending");

    a_last_report_node: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tuser == rmda_pkg::KIND_REPORT && m_axis_tlast
        |-> r_k + LW'(1) == w_live)
        else $error("final report is not for the last live node");

    a_status_is_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tuser == rmda_pkg::KIND_STATUS |-> m_axis_tlast)
        else $error("send status beat without last");

    a_enqueue_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_wr_en |=> r_cnt[$past(w_snd_idx)] == $past(r_cnt[w_snd_idx]) + CW'(1))
        else $error("queue count did not advance on enqueue");

endmodule
